FILE: hw/rtl/rld_pkg.sv
// ----------------------------------------------------------------------------
// rld_pkg: shared definitions for the resistor ladder switch decoder
// Widths, operation codes and the beat structures passed between the
// controller, the level cells and the divider.
// ----------------------------------------------------------------------------
package rld_pkg;

  localparam int SWITCH_COUNT    = 4;
  localparam int ADC_BITS        = 12;
  localparam int TABLE_SIZE      = 1 << SWITCH_COUNT;
  localparam int CAL_SAMPLES_DEF = 20;

  typedef enum logic [1:0] {
    FN_WRITE    = 2'd0,
    FN_CALIB    = 2'd1,
    FN_CLASSIFY = 2'd2,
    FN_NOP      = 2'd3
  } func_t;

  // Search token that travels down the row of level cells.
  typedef struct packed {
    logic                    vld;
    logic [ADC_BITS-1:0]     sample;
    logic [ADC_BITS:0]       best;
    logic [SWITCH_COUNT-1:0] idx;
  } scan_t;

  // Table write broadcast to every cell.
  typedef struct packed {
    logic                    en;
    logic [SWITCH_COUNT-1:0] idx;
    logic [ADC_BITS-1:0]     data;
  } wr_t;

endpackage

FILE: hw/rtl/rld_cell.sv
// ----------------------------------------------------------------------------
// rld_cell: one table entry of the level row
// Holds the calibrated level of one switch combination and compares a
// passing search token against it, handing the token on each cycle.
// ----------------------------------------------------------------------------
module rld_cell
  import rld_pkg::*;
#(
  parameter int CELL_IDX = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  wr_t   wr,
  input  scan_t scan_in,
  output scan_t scan_out
);

  logic [ADC_BITS-1:0] level_r;
  scan_t               scan_r;
  scan_t               scan_nxt;
  logic [ADC_BITS-1:0] diff;

  always_comb begin
    if (scan_in.sample >= level_r) begin
      diff = scan_in.sample - level_r;
    end else begin
      diff = level_r - scan_in.sample;
    end
    scan_nxt = scan_in;
    // Strict compare keeps the lower index on a tie.
    if ({1'b0, diff} < scan_in.best) begin
      scan_nxt.best = {1'b0, diff};
      scan_nxt.idx  = SWITCH_COUNT'(CELL_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= '0;
      scan_r.vld <= 1'b0;
    end else begin
      if (wr.en && (wr.idx == SWITCH_COUNT'(CELL_IDX))) begin
        level_r <= wr.data;
      end
      scan_r.vld <= scan_in.vld;
    end
    scan_r.sample <= scan_nxt.sample;
    scan_r.best   <= scan_nxt.best;
    scan_r.idx    <= scan_nxt.idx;
  end

  assign scan_out = scan_r;

endmodule

FILE: hw/rtl/rld_div.sv
// ----------------------------------------------------------------------------
// rld_div: divider by the calibration sample count
// Multiplies the sum by a rounded-up reciprocal of the sample count and keeps
// the upper bits. The dividend is registered first and the product second;
// done is registered alongside through busy_r and rises with the quotient.
// ----------------------------------------------------------------------------
module rld_div
  import rld_pkg::*;
#(
  parameter int CAL_SAMPLES = CAL_SAMPLES_DEF,
  parameter int SUM_W       = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  // Widening the shift by the bits of the divisor keeps the reciprocal error
  // below one step for every sum that fits in SUM_W bits.
  localparam int DIV_SH = SUM_W + $clog2(CAL_SAMPLES);
  localparam int PROD_W = DIV_SH + SUM_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << DIV_SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
  localparam logic [SUM_W:0] RECIP = (SUM_W+1)'(RECIP_L);

  logic [SUM_W-1:0]  div_r;
  logic              busy_r;
  logic              done_r;
  logic [SUM_W-1:0]  q_r;
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(div_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= start;
      done_r <= busy_r;
    end
    if (start) begin
      div_r <= dividend;
    end
    q_r <= prod[DIV_SH +: SUM_W];
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: hw/rtl/resistor_ladder_switch_decoder.sv
// ----------------------------------------------------------------------------
// resistor_ladder_switch_decoder: nearest-level switch decoder
// Input beats carry func, entry_index and level. One result beat is returned
// for every input beat, in order: the pressed-switch mask, the distance to
// the nearest table level on classify, and the calibration average when a
// calibration run completes.
// The block works on one beat at a time and holds in_stall high meanwhile.
// A table write, a calibration sample that does not finish a run and an
// unused code go from acceptance through ST_PUSH to the result register.
// A classify beat passes a search token through the row of 16 level cells,
// one cell per cycle.
// The sample that completes a calibration run hands its sum to a two-stage
// reciprocal multiplier that divides by the sample count.
// The next beat is accepted in the cycle after the result reaches the output
// register, even while the receiver stalls it. If the output register is
// still full, the finished result waits inside until it drains.
// Reset clears the level table to zero, the calibration sum and count, and the mask.
// ----------------------------------------------------------------------------
module resistor_ladder_switch_decoder
  import rld_pkg::*;
#(
  parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_func,
  input  logic [SWITCH_COUNT-1:0] in_entry_index,
  input  logic [ADC_BITS-1:0]     in_level,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SWITCH_COUNT-1:0] out_pressed_mask,
  output logic [ADC_BITS-1:0]     out_match_distance,
  output logic                    out_calib_done,
  output logic [ADC_BITS-1:0]     out_calib_level
);

  localparam int SUM_W = $clog2(CAL_SAMPLES * (1 << ADC_BITS));
  localparam int CNT_W = $clog2(CAL_SAMPLES + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_PUSH = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [SWITCH_COUNT-1:0] calib_entry_r, calib_entry_nxt;
  logic [SWITCH_COUNT-1:0] pressed_r, pressed_nxt;
  logic [ADC_BITS-1:0]     res_dist_r, res_dist_nxt;
  logic                    res_done_r, res_done_nxt;
  logic [ADC_BITS-1:0]     res_avg_r, res_avg_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SWITCH_COUNT-1:0] out_mask_r;
  logic [ADC_BITS-1:0]     out_dist_r;
  logic                    out_done_r;
  logic [ADC_BITS-1:0]     out_avg_r;

  logic                    accept;
  logic                    out_free;
  func_t                   func;
  logic                    restart;
  logic [SUM_W-1:0]        sum_new;
  logic [CNT_W-1:0]        count_new;
  logic                    div_start;
  logic                    div_done;
  logic [SUM_W-1:0]        div_quot;
  wr_t                     wr;
  scan_t                   chain [TABLE_SIZE+1];

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign func     = func_t'(in_func);

  assign restart   = (count_r == '0) || (in_entry_index != calib_entry_r);
  assign sum_new   = restart ? SUM_W'(in_level) : (sum_r + SUM_W'(in_level));
  assign count_new = restart ? CNT_W'(1) : (count_r + 1'b1);

  // The search token enters the row in the cycle the classify beat is taken.
  always_comb begin
    chain[0].vld    = accept && (func == FN_CLASSIFY);
    chain[0].sample = in_level;
    chain[0].best   = (ADC_BITS+1)'(1) << ADC_BITS;
    chain[0].idx    = '0;
  end

  always_comb begin
    state_nxt       = state_r;
    sum_nxt         = sum_r;
    count_nxt       = count_r;
    calib_entry_nxt = calib_entry_r;
    pressed_nxt     = pressed_r;
    res_dist_nxt    = res_dist_r;
    res_done_nxt    = res_done_r;
    res_avg_nxt     = res_avg_r;
    div_start       = 1'b0;
    wr.en           = 1'b0;
    wr.idx          = in_entry_index;
    wr.data         = in_level;
    out_valid_nxt   = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_dist_nxt = '0;
          res_done_nxt = 1'b0;
          res_avg_nxt  = '0;
          state_nxt    = ST_PUSH;
          case (func)
            FN_WRITE: begin
              wr.en = 1'b1;
            end
            FN_CALIB: begin
              calib_entry_nxt = in_entry_index;
              if (count_new >= CNT_W'(CAL_SAMPLES)) begin
                div_start = 1'b1;
                sum_nxt   = '0;
                count_nxt = '0;
                state_nxt = ST_DIV;
              end else begin
                sum_nxt   = sum_new;
                count_nxt = count_new;
              end
            end
            FN_CLASSIFY: begin
              state_nxt = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (chain[TABLE_SIZE].vld) begin
          pressed_nxt  = chain[TABLE_SIZE].idx;
          res_dist_nxt = chain[TABLE_SIZE].best[ADC_BITS-1:0];
          state_nxt    = ST_PUSH;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          wr.en        = 1'b1;
          wr.idx       = calib_entry_r;
          wr.data      = div_quot[ADC_BITS-1:0];
          res_done_nxt = 1'b1;
          res_avg_nxt  = div_quot[ADC_BITS-1:0];
          state_nxt    = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      sum_r         <= '0;
      count_r       <= '0;
      calib_entry_r <= '0;
      pressed_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      sum_r         <= sum_nxt;
      count_r       <= count_nxt;
      calib_entry_r <= calib_entry_nxt;
      pressed_r     <= pressed_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    res_dist_r <= res_dist_nxt;
    res_done_r <= res_done_nxt;
    res_avg_r  <= res_avg_nxt;
    if ((state_r == ST_PUSH) && out_free) begin
      out_mask_r <= pressed_r;
      out_dist_r <= res_dist_r;
      out_done_r <= res_done_r;
      out_avg_r  <= res_avg_r;
    end
  end

  for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_cell
    rld_cell #(
      .CELL_IDX(i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr      (wr),
      .scan_in (chain[i]),
      .scan_out(chain[i+1])
    );
  end

  rld_div #(
    .CAL_SAMPLES(CAL_SAMPLES),
    .SUM_W      (SUM_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(sum_new),
    .done    (div_done),
    .quotient(div_quot)
  );

  assign out_valid          = out_valid_r;
  assign out_pressed_mask   = out_mask_r;
  assign out_match_distance = out_dist_r;
  assign out_calib_done     = out_done_r;
  assign out_calib_level    = out_avg_r;

endmodule

FILE: hw/rtl/rld_chk.sv
// ----------------------------------------------------------------------------
// rld_chk: port-level checks for the resistor ladder switch decoder
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module rld_chk
  import rld_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic [1:0]              in_func,
  input logic [SWITCH_COUNT-1:0] in_entry_index,
  input logic [ADC_BITS-1:0]     in_level,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [SWITCH_COUNT-1:0] out_pressed_mask,
  input logic [ADC_BITS-1:0]     out_match_distance,
  input logic                    out_calib_done,
  input logic [ADC_BITS-1:0]     out_calib_level
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // Only one beat is in flight, so the input closes right after a beat.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second input beat taken while one is in flight");

  // A calibration result never carries a match distance.
  a_calib_no_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_calib_done |-> out_match_distance == '0)
    else $error("distance reported on a calibration result");

  // The average is reported only on the beat that completes a run.
  a_level_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_calib_done |-> out_calib_level == '0)
    else $error("calibration level without completed run");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat offered after reset");

endmodule

bind resistor_ladder_switch_decoder rld_chk u_rld_chk (.*);

FILE: verif/decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decode_checker: result checker for the resistor ladder switch decoder
// Tracks the level table, the calibration average and the pressed mask for
// every input beat taken. Each result beat is compared field by field with
// the oldest expected result. Mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module decode_checker
  import rld_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [1:0]              in_func,
  input  logic [SWITCH_COUNT-1:0] in_entry_index,
  input  logic [ADC_BITS-1:0]     in_level,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [SWITCH_COUNT-1:0] out_pressed_mask,
  input  logic [ADC_BITS-1:0]     out_match_distance,
  input  logic                    out_calib_done,
  input  logic [ADC_BITS-1:0]     out_calib_level,
  output int                      fail_count,
  output int                      pending_count,
  output int                      checked_count,
  output int                      calib_done_count
);

  // 20 samples of 4095 still fit in 17 bits.
  localparam int SUM_BITS = 17;

  typedef struct packed {
    logic [SWITCH_COUNT-1:0] pressed_mask;
    logic [ADC_BITS-1:0]     match_distance;
    logic                    calib_done;
    logic [ADC_BITS-1:0]     calib_level;
  } decode_result_t;

  logic [ADC_BITS-1:0]     level_store [TABLE_SIZE];
  logic [SUM_BITS-1:0]     run_sum;
  logic [4:0]              run_count;
  logic [SWITCH_COUNT-1:0] run_entry;
  logic [SWITCH_COUNT-1:0] mask_state;
  decode_result_t          decode_q [$];

  // Applies one input beat to the tracked state and returns its result.
  function automatic decode_result_t decode_beat(logic [1:0] func,
                                                 logic [SWITCH_COUNT-1:0] idx,
                                                 logic [ADC_BITS-1:0] lvl);
    decode_result_t r;
    logic [ADC_BITS:0] best;
    logic [ADC_BITS:0] gap;
    r = '0;
    case (func_t'(func))
      FN_WRITE: level_store[idx] = lvl;
      FN_CALIB: begin
        // A different entry drops the running sum and starts a new run.
        if (run_count == 0 || idx != run_entry) begin
          run_entry = idx;
          run_sum   = SUM_BITS'(lvl);
          run_count = 5'd1;
        end else begin
          run_sum   = run_sum + SUM_BITS'(lvl);
          run_count = run_count + 5'd1;
        end
        if (run_count >= CAL_SAMPLES_DEF) begin
          r.calib_level          = ADC_BITS'(run_sum / CAL_SAMPLES_DEF);
          r.calib_done           = 1'b1;
          level_store[run_entry] = r.calib_level;
          run_sum                = '0;
          run_count              = '0;
        end
      end
      FN_CLASSIFY: begin
        best = (ADC_BITS+1)'(1 << ADC_BITS);
        for (int i = 0; i < TABLE_SIZE; i++) begin
          gap = (lvl >= level_store[i]) ? (ADC_BITS+1)'(lvl - level_store[i])
                                        : (ADC_BITS+1)'(level_store[i] - lvl);
          // Strict compare keeps the lowest index on a tie.
          if (gap < best) begin
            best       = gap;
            mask_state = SWITCH_COUNT'(i);
          end
        end
        r.match_distance = best[ADC_BITS-1:0];
      end
      default: ;
    endcase
    r.pressed_mask = mask_state;
    return r;
  endfunction

  always @(posedge clk) begin
    decode_result_t want;
    if (!rst_n) begin
      foreach (level_store[i]) level_store[i] = '0;
      run_sum    = '0;
      run_count  = '0;
      run_entry  = '0;
      mask_state = '0;
      decode_q.delete();
    end else begin
      // The result side goes first so that a beat taken at this edge is never
      // matched against a result leaving at the same edge.
      if (out_valid && !out_stall) begin
        if (decode_q.size() == 0) begin
          $error("result beat with nothing expected: pressed_mask %0d, match_distance %0d",
                 out_pressed_mask, out_match_distance);
          fail_count++;
        end else begin
          want = decode_q.pop_front();
          checked_count++;
          if (out_calib_done === 1'b1) calib_done_count++;
          if (out_pressed_mask !== want.pressed_mask) begin
            $error("pressed_mask: expected %0d, actual %0d", want.pressed_mask,
                   out_pressed_mask);
            fail_count++;
          end
          if (out_match_distance !== want.match_distance) begin
            $error("match_distance: expected %0d, actual %0d", want.match_distance,
                   out_match_distance);
            fail_count++;
          end
          if (out_calib_done !== want.calib_done) begin
            $error("calib_done: expected %0d, actual %0d", want.calib_done,
                   out_calib_done);
            fail_count++;
          end
          if (out_calib_level !== want.calib_level) begin
            $error("calib_level: expected %0d, actual %0d", want.calib_level,
                   out_calib_level);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        decode_q.push_back(decode_beat(in_func, in_entry_index, in_level));
      end
    end
    pending_count = decode_q.size();
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the resistor ladder switch decoder
// A directed opening covers the reset table, writes, ties, the unused code
// and calibration interruptions. Random beats follow, mostly full
// calibration runs with writes and classifies mixed in, over four phases of
// sender idling and receiver stalls. Results are checked by decode_checker.
// ----------------------------------------------------------------------------
module tb;
  import rld_pkg::*;

  localparam int PHASE_BEATS  = 350;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 600000;

  logic                    clk            = 1'b0;
  logic                    rst_n          = 1'b0;
  logic                    in_valid       = 1'b0;
  logic [1:0]              in_func        = '0;
  logic [SWITCH_COUNT-1:0] in_entry_index = '0;
  logic [ADC_BITS-1:0]     in_level       = '0;
  logic                    out_stall      = 1'b0;
  logic                    in_stall;
  logic                    out_valid;
  logic [SWITCH_COUNT-1:0] out_pressed_mask;
  logic [ADC_BITS-1:0]     out_match_distance;
  logic                    out_calib_done;
  logic [ADC_BITS-1:0]     out_calib_level;

  int          fail_count;
  int          pending_count;
  int          checked_count;
  int          calib_done_count;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          beats_sent     = 0;
  int unsigned cycle_count    = 0;

  resistor_ladder_switch_decoder i_dut (.*);

  decode_checker i_checker (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Presents one beat after a random idle stretch and holds it until taken.
  task automatic send_beat(func_t f, logic [SWITCH_COUNT-1:0] idx,
                           logic [ADC_BITS-1:0] lvl);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= f;
    in_entry_index <= idx;
    in_level       <= lvl;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // Stops sending until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_count == 0);
  endtask

  // One calibration run, sometimes cut short, with the odd write or classify
  // slipped in between samples.
  task automatic calib_run();
    logic [SWITCH_COUNT-1:0] entry;
    logic [ADC_BITS-1:0]     base;
    logic [ADC_BITS-1:0]     sample;
    int                      len;
    int                      style;
    int                      jitter;
    entry = SWITCH_COUNT'($urandom_range(TABLE_SIZE-1));
    base  = ADC_BITS'($urandom_range(4095));
    style = $urandom_range(3);
    len   = ($urandom_range(9) == 0) ? $urandom_range(1, CAL_SAMPLES_DEF-1)
                                     : CAL_SAMPLES_DEF;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(15) == 0) begin
        if ($urandom_range(1) == 1) begin
          send_beat(FN_WRITE, $urandom_range(1) ? entry
                                                : SWITCH_COUNT'($urandom_range(15)),
                    ADC_BITS'($urandom_range(4095)));
        end else begin
          send_beat(FN_CLASSIFY, SWITCH_COUNT'($urandom_range(15)),
                    ADC_BITS'($urandom_range(4095)));
        end
      end
      case (style)
        0: sample = ADC_BITS'($urandom_range(4095));
        1: sample = '1;
        2: sample = '0;
        default: begin
          jitter = int'(base) + $urandom_range(64) - 32;
          sample = (jitter < 0) ? '0 : (jitter > 4095) ? '1 : ADC_BITS'(jitter);
        end
      endcase
      send_beat(FN_CALIB, entry, sample);
    end
  endtask

  initial begin
    int target;
    int pick;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening on the cleared table.
    send_beat(FN_CLASSIFY, 4'd0, 12'd4095);
    send_beat(FN_NOP, 4'd15, 12'd4095);
    send_beat(FN_WRITE, 4'd15, 12'd4095);
    send_beat(FN_WRITE, 4'd3, 12'd100);
    send_beat(FN_WRITE, 4'd5, 12'd100);
    send_beat(FN_CLASSIFY, 4'd0, 12'd100);
    send_beat(FN_CLASSIFY, 4'd9, 12'd50);
    send_beat(FN_CLASSIFY, 4'd0, 12'd4095);
    send_beat(FN_CLASSIFY, 4'd0, 12'd0);
    send_beat(FN_CALIB, 4'd7, 12'd4095);
    send_beat(FN_CALIB, 4'd9, 12'd1);
    send_beat(FN_WRITE, 4'd9, 12'd2000);
    send_beat(FN_CLASSIFY, 4'd0, 12'd2000);
    send_beat(FN_NOP, 4'd0, 12'd0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          calib_run();
        end else if (pick < 70) begin
          send_beat(FN_WRITE, SWITCH_COUNT'($urandom_range(15)),
                    ADC_BITS'($urandom_range(4095)));
        end else if (pick < 95) begin
          send_beat(FN_CLASSIFY, SWITCH_COUNT'($urandom_range(15)),
                    ($urandom_range(7) == 0) ? ADC_BITS'($urandom_range(1) * 4095)
                                             : ADC_BITS'($urandom_range(4095)));
        end else begin
          send_beat(FN_NOP, SWITCH_COUNT'($urandom_range(15)),
                    ADC_BITS'($urandom_range(4095)));
        end
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d beats over four idle and stall phases; %0d results checked.",
             beats_sent, checked_count);
    $display("Calibration runs completed and stored: %0d.", calib_done_count);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
